[rtl/pjce_pkg.sv]
// ----------------------------------------------------------------------------
// pjce_pkg: shared types and constants
// Fixed-point widths, the statistics word layout and the sequencer states.
// ----------------------------------------------------------------------------
package pjce_pkg;

   localparam int VAL_W  = 56;           // Q40.16 running values
   localparam int HALF_W = VAL_W / 2;    // multiplier operand slice
   localparam int PROD_W = 2 * VAL_W;
   localparam int STAT_W = 32;
   localparam int WORD_W = 3 * STAT_W;   // {starts, ends, edge count}
   localparam int EST_W  = 32;

   localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_STEP = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_DIV1,
      ST_MUL1,
      ST_DIV2,
      ST_MUL2,
      ST_DONE
   } pjce_state_type;

endpackage

[rtl/pjce_mem.sv]
// ----------------------------------------------------------------------------
// pjce_mem: label statistics memory
// One write port and one read port; read data registered, valid the cycle after rd_en.
// ----------------------------------------------------------------------------
module pjce_mem
   import pjce_pkg::*;
#(
   parameter int LABELS = 256
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [7:0]        wr_label,
   input  logic [WORD_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [7:0]        rd_label,
   output logic [WORD_W-1:0] rd_data
);

   localparam int AW = (LABELS > 1) ? $clog2(LABELS) : 1;

   logic [WORD_W-1:0] mem [LABELS];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[AW'(wr_label)] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[AW'(rd_label)];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/pjce_div.sv]
// ----------------------------------------------------------------------------
// pjce_div: serial fixed-point divider
// Computes (num << FRAC_BITS) / den one quotient bit per cycle, saturated; a zero den gives zero.
// ----------------------------------------------------------------------------
module pjce_div
   import pjce_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [VAL_W-1:0] num,
   input  logic [VAL_W-1:0] den,
   output logic             done,
   output logic [VAL_W-1:0] quot
);

   localparam int QW = VAL_W + FRAC_BITS;
   localparam int CW = $clog2(QW + 1);

   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [QW-1:0]    sh_ff, sh_in;
   logic [QW-1:0]    q_ff, q_in;
   logic [VAL_W-1:0] rem_ff, rem_in;
   logic [VAL_W-1:0] den_ff, den_in;
   logic [VAL_W-1:0] quot_ff, quot_in;
   logic [VAL_W:0]   rem_sh;
   logic [VAL_W:0]   diff;
   logic             ge;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      sh_in   = sh_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      rem_sh  = {rem_ff, sh_ff[QW-1]};
      diff    = rem_sh - {1'b0, den_ff};
      ge      = (rem_sh >= {1'b0, den_ff});
      if (start) begin
         run_in = 1'b1;
         cnt_in = CW'(QW);
         sh_in  = QW'(num) << FRAC_BITS;
         q_in   = '0;
         rem_in = '0;
         den_in = den;
      end else if (run_ff) begin
         // shift in the next dividend bit, subtract when it fits
         sh_in  = sh_ff << 1;
         q_in   = {q_ff[QW-2:0], ge};
         rem_in = ge ? diff[VAL_W-1:0] : rem_sh[VAL_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
      if (done_ff) begin
         if (den_ff == '0) begin
            quot_in = '0;
         end else if ((q_ff >> VAL_W) != '0) begin
            quot_in = VAL_MAX;
         end else begin
            quot_in = q_ff[VAL_W-1:0];
         end
      end
   end

   logic out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         out_ff  <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         out_ff  <= done_ff;
      end
      cnt_ff  <= cnt_in;
      sh_ff   <= sh_in;
      q_ff    <= q_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign done = out_ff;
   assign quot = quot_ff;

endmodule

[rtl/pjce_mul.sv]
// ----------------------------------------------------------------------------
// pjce_mul: multi-cycle multiplier
// 56x56 product from four 28x28 partial products, optional right shift by
// FRAC_BITS, saturated to 56 bits.
// ----------------------------------------------------------------------------
module pjce_mul
   import pjce_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [VAL_W-1:0] a,
   input  logic [VAL_W-1:0] b,
   input  logic             shr,
   output logic             done,
   output logic [VAL_W-1:0] prod
);

   logic              run_ff, run_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic [VAL_W-1:0]  a_ff, a_in;
   logic [VAL_W-1:0]  b_ff, b_in;
   logic              shr_ff, shr_in;
   logic [2*HALF_W-1:0] p_ff, p_in;
   logic [1:0]        psh_ff, psh_in;
   logic              pv_ff, pv_in;
   logic              plast_ff, plast_in;
   logic [PROD_W-1:0] acc_ff, acc_in;
   logic              fin_ff, fin_in;
   logic              done_ff, done_in;
   logic [VAL_W-1:0]  prod_ff, prod_in;
   logic [HALF_W-1:0] a_half, b_half;
   logic [PROD_W-1:0] shifted;

   always_comb begin
      run_in   = run_ff;
      cnt_in   = cnt_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      shr_in   = shr_ff;
      acc_in   = acc_ff;
      prod_in  = prod_ff;
      a_half   = cnt_ff[1] ? a_ff[VAL_W-1:HALF_W] : a_ff[HALF_W-1:0];
      b_half   = cnt_ff[0] ? b_ff[VAL_W-1:HALF_W] : b_ff[HALF_W-1:0];
      p_in     = a_half * b_half;
      psh_in   = 2'(cnt_ff[1]) + 2'(cnt_ff[0]);
      pv_in    = run_ff;
      plast_in = run_ff && (cnt_ff == 2'd3);
      fin_in   = pv_ff && plast_ff;
      done_in  = fin_ff;
      shifted  = shr_ff ? (acc_ff >> FRAC_BITS) : acc_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         a_in   = a;
         b_in   = b;
         shr_in = shr;
         acc_in = '0;
      end else begin
         if (run_ff) begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 2'd3) begin
               run_in = 1'b0;
            end
         end
         if (pv_ff) begin
            acc_in = acc_ff + (PROD_W'(p_ff) << (HALF_W * int'(psh_ff)));
         end
      end
      if (fin_ff) begin
         prod_in = (shifted[PROD_W-1:VAL_W] != '0) ? VAL_MAX : shifted[VAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         pv_ff    <= 1'b0;
         plast_ff <= 1'b0;
         fin_ff   <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         run_ff   <= run_in;
         pv_ff    <= pv_in;
         plast_ff <= plast_in;
         fin_ff   <= fin_in;
         done_ff  <= done_in;
      end
      cnt_ff  <= cnt_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      shr_ff  <= shr_in;
      p_ff    <= p_in;
      psh_ff  <= psh_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
   end

   assign done = done_ff;
   assign prod = prod_ff;

endmodule

[rtl/path_join_cardinality_estimator.sv]
// ----------------------------------------------------------------------------
// path_join_cardinality_estimator: path query result size estimator
// Holds per-label edge statistics in memory and folds path steps into a
// running Q40.16 size estimate.
// ----------------------------------------------------------------------------
// Usage:
//   A request is a transfer when start is high and busy is low.
//   req_action = load writes the three statistics of req_label into the
//   statistics memory; busy stays low, so a load can follow
//   every cycle. A load with a label not below LABELS is dropped.
//   req_action = step reads the label's statistics (registered memory read)
//   and advances the running size. The first step of a path only seeds the
//   running values and keeps busy high through ST_READ and ST_DONE; a later
//   step runs two serial divisions, each followed by a four-slice
//   multiplication, in the order divide, multiply, divide, multiply.
//   busy is high for the whole step.
//   A step with req_last high ends the path and presents the estimate on
//   rsp_estimate/rsp_saturated for one cycle with rsp_valid, in the first
//   cycle that busy is low. The receiver cannot stall; the result is a
//   transfer in that cycle.
//   Reset clears the running size, running distinct count and the path flag;
//   the statistics memory is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module path_join_cardinality_estimator
   import pjce_pkg::*;
#(
   parameter int LABELS    = 256,
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_action,
   input  logic [7:0]        req_label,
   input  logic [STAT_W-1:0] req_edge_count,
   input  logic [STAT_W-1:0] req_distinct_ends,
   input  logic [STAT_W-1:0] req_distinct_starts,
   input  logic              req_inverse,
   input  logic              req_last,
   output logic              rsp_valid,
   output logic [EST_W-1:0]  rsp_estimate,
   output logic              rsp_saturated
);

   pjce_state_type state_ff, state_in;

   logic              accept;
   logic              label_ok;
   logic              mem_wr, mem_rd;
   logic [WORD_W-1:0] mem_rdata;

   logic              ok_ff, ok_in;
   logic              inv_ff, inv_in;
   logic              last_ff, last_in;
   logic              inside_ff, inside_in;
   logic [STAT_W-1:0] ts_ff, ts_in;
   logic [STAT_W-1:0] ends_ff, ends_in;
   logic [STAT_W-1:0] starts_ff, starts_in;
   logic [VAL_W-1:0]  rs_ff, rs_in;
   logic [VAL_W-1:0]  rd_ff, rd_in;
   logic [VAL_W-1:0]  t1_ff, t1_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [EST_W-1:0]  est_ff, est_in;
   logic              sat_ff, sat_in;

   logic [STAT_W-1:0] ts_v, ends_v, starts_v;
   logic              div_start, div_done;
   logic [VAL_W-1:0]  div_num, div_den, div_quot;
   logic              mul_start, mul_done, mul_shr;
   logic [VAL_W-1:0]  mul_a, mul_b, mul_prod;
   logic [VAL_W-1:0]  join_v, nv_v, whole_v;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign label_ok = (32'(req_label) < LABELS);
   assign mem_wr   = accept && (req_action == ACT_LOAD) && label_ok;
   assign mem_rd   = accept && (req_action == ACT_STEP);

   pjce_mem #(
      .LABELS(LABELS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_label(req_label),
      .wr_data ({req_distinct_starts, req_distinct_ends, req_edge_count}),
      .rd_en   (mem_rd),
      .rd_label(req_label),
      .rd_data (mem_rdata)
   );

   pjce_div #(
      .FRAC_BITS(FRAC_BITS)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num  (div_num),
      .den  (div_den),
      .done (div_done),
      .quot (div_quot)
   );

   pjce_mul #(
      .FRAC_BITS(FRAC_BITS)
   ) u_mul (
      .clock(clock),
      .reset(reset),
      .start(mul_start),
      .a    (mul_a),
      .b    (mul_b),
      .shr  (mul_shr),
      .done (mul_done),
      .prod (mul_prod)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         inside_ff    <= 1'b0;
         rs_ff        <= '0;
         rd_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         inside_ff    <= inside_in;
         rs_ff        <= rs_in;
         rd_ff        <= rd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ok_ff     <= ok_in;
      inv_ff    <= inv_in;
      last_ff   <= last_in;
      ts_ff     <= ts_in;
      ends_ff   <= ends_in;
      starts_ff <= starts_in;
      t1_ff     <= t1_in;
      est_ff    <= est_in;
      sat_ff    <= sat_in;
   end

   always_comb begin
      state_in     = state_ff;
      ok_in        = ok_ff;
      inv_in       = inv_ff;
      last_in      = last_ff;
      inside_in    = inside_ff;
      ts_in        = ts_ff;
      ends_in      = ends_ff;
      starts_in    = starts_ff;
      rs_in        = rs_ff;
      rd_in        = rd_ff;
      t1_in        = t1_ff;
      rsp_valid_in = 1'b0;
      est_in       = est_ff;
      sat_in       = sat_ff;
      div_start    = 1'b0;
      div_num      = rs_ff;
      div_den      = rd_ff;
      mul_start    = 1'b0;
      mul_a        = rs_ff;
      mul_b        = div_quot;
      mul_shr      = 1'b1;

      // labels out of range read as zero statistics
      ts_v     = ok_ff ? mem_rdata[STAT_W-1:0]          : '0;
      ends_v   = ok_ff ? mem_rdata[2*STAT_W-1:STAT_W]   : '0;
      starts_v = ok_ff ? mem_rdata[3*STAT_W-1:2*STAT_W] : '0;

      join_v  = (t1_ff < mul_prod) ? t1_ff : mul_prod;
      nv_v    = VAL_W'(inv_ff ? ends_ff : starts_ff) << FRAC_BITS;
      whole_v = rs_ff >> FRAC_BITS;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_action == ACT_STEP)) begin
               ok_in    = label_ok;
               inv_in   = req_inverse;
               last_in  = req_last;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            ts_in     = ts_v;
            ends_in   = ends_v;
            starts_in = starts_v;
            if (!inside_ff) begin
               // first step: seed the running values
               rs_in    = VAL_W'(ts_v) << FRAC_BITS;
               rd_in    = VAL_W'(inv_ff ? ends_v : starts_v) << FRAC_BITS;
               state_in = ST_DONE;
            end else begin
               div_start = 1'b1;
               div_num   = VAL_W'(ts_v);
               div_den   = VAL_W'(inv_ff ? starts_v : ends_v);
               state_in  = ST_DIV1;
            end
         end
         ST_DIV1: begin
            if (div_done) begin
               mul_start = 1'b1;
               mul_a     = rs_ff;
               mul_b     = div_quot;
               mul_shr   = 1'b1;
               state_in  = ST_MUL1;
            end
         end
         ST_MUL1: begin
            if (mul_done) begin
               t1_in     = mul_prod;
               div_start = 1'b1;
               div_num   = rs_ff;
               div_den   = rd_ff;
               state_in  = ST_DIV2;
            end
         end
         ST_DIV2: begin
            if (div_done) begin
               mul_start = 1'b1;
               mul_a     = VAL_W'(ts_ff);
               mul_b     = div_quot;
               mul_shr   = 1'b0;
               state_in  = ST_MUL2;
            end
         end
         ST_MUL2: begin
            if (mul_done) begin
               rs_in    = join_v;
               rd_in    = (nv_v < join_v) ? nv_v : join_v;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // emit on the last step, otherwise hold the path open
            rsp_valid_in = last_ff;
            inside_in    = !last_ff;
            sat_in       = (whole_v[VAL_W-1:EST_W] != '0);
            est_in       = sat_in ? {EST_W{1'b1}} : whole_v[EST_W-1:0];
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_estimate  = est_ff;
   assign rsp_saturated = sat_ff;

endmodule

[bench/path_join_cardinality_estimator_tb.sv]
// ----------------------------------------------------------------------------
// path_join_cardinality_estimator_tb: self-checking bench for the estimator
// Loads label statistics, walks paths of one to several steps and compares
// each emitted estimate against an in-bench Q40.16 predictor.
// ----------------------------------------------------------------------------
module path_join_cardinality_estimator_tb;
   import pjce_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC     = 16;
   localparam int WD_LIMIT = 4000;   // idle cycles before the run is abandoned

   typedef struct packed {
      logic [EST_W-1:0] estimate;
      logic             saturated;
   } estimate_type;

   // Path estimate predictor plus the queue of estimates still owed.
   class estimate_board;
      logic [STAT_W-1:0] edges_mem  [256];
      logic [STAT_W-1:0] ends_mem   [256];
      logic [STAT_W-1:0] starts_mem [256];
      logic [VAL_W-1:0]  size_q;
      logic [VAL_W-1:0]  distinct_q;
      bit                in_path;
      estimate_type      owed_q[$];
      int                errors;

      function new();
         size_q = '0;
         distinct_q = '0;
         in_path = 0;
         errors = 0;
      endfunction

      // (num << FRAC) / den, clipped to 56 bits; zero divisor yields zero
      function logic [VAL_W-1:0] quot(logic [VAL_W-1:0] num, logic [VAL_W-1:0] den);
         logic [VAL_W+FRAC-1:0] q;
         if (den == '0) return '0;
         q = {num, {FRAC{1'b0}}} / {{FRAC{1'b0}}, den};
         return (q > VAL_MAX) ? VAL_MAX : q[VAL_W-1:0];
      endfunction

      function logic [VAL_W-1:0] mul_shift(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b,
                                           int s);
         logic [PROD_W-1:0] p;
         p = {{VAL_W{1'b0}}, a} * {{VAL_W{1'b0}}, b};
         p = p >> s;
         return (p > VAL_MAX) ? VAL_MAX : p[VAL_W-1:0];
      endfunction

      function void note_request(logic act, logic [7:0] lab, logic [STAT_W-1:0] ec,
                                 logic [STAT_W-1:0] de, logic [STAT_W-1:0] ds,
                                 logic inv, logic lst);
         logic [VAL_W-1:0] ts, ends, starts, t1, t2, join_sz, nv;
         logic [VAL_W-FRAC-1:0] whole;
         estimate_type e;
         if (act == ACT_LOAD) begin
            edges_mem[lab] = ec;
            ends_mem[lab] = de;
            starts_mem[lab] = ds;
            return;
         end
         ts = VAL_W'(edges_mem[lab]);
         ends = VAL_W'(ends_mem[lab]);
         starts = VAL_W'(starts_mem[lab]);
         if (!in_path) begin
            size_q = ts << FRAC;
            distinct_q = (inv ? ends : starts) << FRAC;
         end else begin
            t1 = mul_shift(size_q, quot(ts, inv ? starts : ends), FRAC);
            t2 = mul_shift(ts, quot(size_q, distinct_q), 0);
            join_sz = (t1 < t2) ? t1 : t2;
            nv = (inv ? ends : starts) << FRAC;
            size_q = join_sz;
            distinct_q = (nv < join_sz) ? nv : join_sz;
         end
         in_path = !lst;
         if (!lst) return;
         whole = (VAL_W-FRAC)'(size_q >> FRAC);
         e.saturated = (whole > {EST_W{1'b1}});
         e.estimate = e.saturated ? {EST_W{1'b1}} : whole[EST_W-1:0];
         owed_q.push_back(e);
      endfunction

      function void check_estimate(logic [EST_W-1:0] est, logic sat);
         estimate_type e;
         if (owed_q.size() == 0) begin
            $error("unexpected estimate %0d (saturated %0b)", est, sat);
            errors++;
            return;
         end
         e = owed_q.pop_front();
         if (est !== e.estimate) begin
            $error("estimate: expected %0d, got %0d", e.estimate, est);
            errors++;
         end
         if (sat !== e.saturated) begin
            $error("saturated: expected %0b, got %0b", e.saturated, sat);
            errors++;
         end
      endfunction
   endclass

   logic              clock = 0;
   logic              reset = 1;
   logic              start = 0;
   logic              busy;
   logic              req_action = ACT_LOAD;
   logic [7:0]        req_label = '0;
   logic [STAT_W-1:0] req_edge_count = '0;
   logic [STAT_W-1:0] req_distinct_ends = '0;
   logic [STAT_W-1:0] req_distinct_starts = '0;
   logic              req_inverse = 0;
   logic              req_last = 0;
   logic              rsp_valid;
   logic [EST_W-1:0]  rsp_estimate;
   logic              rsp_saturated;

   estimate_board board = new();
   bit  loaded [256];
   int  sent = 0;
   bit  steady = 0;       // no sender idling while set
   int  quiet_cycles = 0;

   always #6 clock = ~clock;

   path_join_cardinality_estimator dut (.*);

   // Observe transfers on both channels with pre-edge values.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) board.check_estimate(rsp_estimate, rsp_saturated);
         if (start && !busy)
            board.note_request(req_action, req_label, req_edge_count,
                               req_distinct_ends, req_distinct_starts,
                               req_inverse, req_last);
      end
   end

   // Watchdog: abort when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WD_LIMIT) begin
         $display("path_join_cardinality_estimator_tb failed");
         $finish;
      end
   end

   // Random statistic: full range, tiny, or one of the extremes.
   function automatic logic [STAT_W-1:0] rand_stat();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return $urandom_range(0, 15);
         3: return $urandom >> $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   // Drive one request and hold it until the transfer happens.
   task automatic send(logic act, logic [7:0] lab, logic [STAT_W-1:0] ec,
                       logic [STAT_W-1:0] de, logic [STAT_W-1:0] ds,
                       logic inv, logic lst);
      int gap;
      gap = (!steady && $urandom_range(0, 99) < 35) ? $urandom_range(1, 5) : 0;
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
      start <= 1;
      req_action <= act;
      req_label <= lab;
      req_edge_count <= ec;
      req_distinct_ends <= de;
      req_distinct_starts <= ds;
      req_inverse <= inv;
      req_last <= lst;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (act == ACT_LOAD) loaded[lab] = 1'b1;
      sent++;
   endtask

   // Load with random content in the step-only fields.
   task automatic load(logic [7:0] lab, logic [STAT_W-1:0] ec,
                       logic [STAT_W-1:0] de, logic [STAT_W-1:0] ds);
      send(ACT_LOAD, lab, ec, de, ds, 1'($urandom_range(0, 1)),
           1'($urandom_range(0, 1)));
   endtask

   // Step with random content in the load-only fields.
   task automatic step(logic [7:0] lab, logic inv, logic lst);
      send(ACT_STEP, lab, rand_stat(), rand_stat(), rand_stat(), inv, lst);
   endtask

   function automatic logic [7:0] pick_loaded();
      logic [7:0] l;
      do l = 8'($urandom_range(0, 255)); while (!loaded[l]);
      return l;
   endfunction

   initial begin
      int plen;
      repeat (8) @(posedge clock);
      reset <= 0;

      // Directed: extremes of the statistics and each corner of the math.
      load(8'd0, '1, 32'd1, 32'd1);              // huge label, unit distincts
      load(8'd255, '0, '0, '0);                  // all-zero label
      load(8'd1, 32'd1000, 32'd10, 32'd50);
      load(8'd2, 32'd500, '1, 32'd7);
      load(8'd170, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678);
      step(8'd1, 0, 1);                          // single-step path
      step(8'd1, 1, 1);
      step(8'd0, 0, 0);                          // drive into saturation
      step(8'd0, 0, 1);
      step(8'd255, 0, 0);                        // zero size, zero distinct
      step(8'd1, 0, 1);
      step(8'd1, 0, 0);                          // new path; its later step divides by zero
      step(8'd255, 1, 1);
      step(8'd1, 1, 0);
      step(8'd2, 1, 0);
      load(8'd2, 32'd9, 32'd3, 32'd4);           // load in the middle of a path
      step(8'd2, 0, 0);
      step(8'd170, 1, 1);
      step(8'd170, 0, 0);
      step(8'd0, 1, 1);

      // Hold off until every owed estimate is back.
      start <= 0;
      @(posedge clock);
      while (board.owed_q.size() != 0) @(posedge clock);

      // Random: mostly well-formed paths, with loads sprinkled anywhere.
      for (int l = 0; l < 256; l += 17) load(8'(l), rand_stat(), rand_stat(), rand_stat());
      while (sent < 900) begin
         steady = (sent >= 400 && sent < 550);
         if ($urandom_range(0, 3) == 0) begin
            load(8'($urandom_range(0, 255)), rand_stat(), rand_stat(), rand_stat());
         end else begin
            plen = $urandom_range(1, 5);
            for (int i = 0; i < plen; i++) begin
               if ($urandom_range(0, 9) == 0)
                  load(8'($urandom_range(0, 255)), rand_stat(), rand_stat(),
                       rand_stat());
               step(pick_loaded(), 1'($urandom_range(0, 1)), i == plen - 1);
            end
         end
      end
      start <= 0;

      // Drain owed estimates, then let the pipeline settle.
      @(posedge clock);
      while (board.owed_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (board.errors == 0)
         $display("path_join_cardinality_estimator_tb passed");
      else
         $display("path_join_cardinality_estimator_tb failed");
      $finish;
   end

endmodule
